>>> rtl/i2cmbe_pkg.sv
`default_nettype none

package i2cmbe_pkg;

  // request codes carried in s_tuser
  localparam logic [2:0] REQ_IDLE   = 3'd0;
  localparam logic [2:0] REQ_START  = 3'd1;
  localparam logic [2:0] REQ_STOP   = 3'd2;
  localparam logic [2:0] REQ_WRITE  = 3'd3;
  localparam logic [2:0] REQ_READ   = 3'd4;
  localparam logic [2:0] REQ_ACKW   = 3'd5;
  localparam logic [2:0] REQ_SAMPLE = 3'd6;

  // configuration register indexes
  localparam logic [1:0] CFG_SETUP  = 2'd0;
  localparam logic [1:0] CFG_HALF   = 2'd1;
  localparam logic [1:0] CFG_SAMPLE = 2'd2;
  localparam logic [1:0] CFG_TMO    = 2'd3;

  localparam logic [7:0] SETUP_RST  = 8'd4;
  localparam logic [7:0] HALF_RST   = 8'd2;
  localparam logic [7:0] SAMPLE_RST = 8'd1;
  localparam logic [7:0] TMO_RST    = 8'd250;

  localparam logic [3:0] READ_BITS  = 4'd8;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_READ = 2'd1,
    PEND_ACK  = 2'd2
  } pend_t;

  typedef enum logic [1:0] {
    ACK_NONE = 2'd0,
    ACK_OK   = 2'd1,
    ACK_FAIL = 2'd2
  } ack_t;

  typedef enum logic [3:0] {
    RUN_IDLE,
    RUN_START,
    RUN_STOP,
    RUN_WRITE,
    RUN_READ,
    RUN_ACKW,
    RUN_POLL,
    RUN_ACKOK,
    RUN_RDBIT,
    RUN_RDLAST
  } run_t;

  typedef struct packed {
    logic [7:0] setup_wait;
    logic [7:0] half_bit_wait;
    logic [7:0] sample_wait;
    logic [7:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_sample;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic [7:0] wait_us;
    logic       sample_request;
  } pin_t;

  typedef struct packed {
    pin_t       pin;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [1:0] ack_status;
    logic       last;
  } step_t;

  // a released data line always reads back high
  function automatic pin_t mk_pin(input logic scl, input logic sda, input logic drv,
                                  input logic [7:0] w, input logic req);
    pin_t p;
    p.scl_level      = scl;
    p.sda_level      = drv ? sda : 1'b1;
    p.sda_drive      = drv;
    p.wait_us        = w;
    p.sample_request = req;
    return p;
  endfunction

  function automatic logic [4:0] run_len(input run_t r);
    logic [4:0] n;
    case (r)
      RUN_IDLE:   n = 5'd1;
      RUN_START:  n = 5'd4;
      RUN_STOP:   n = 5'd4;
      RUN_WRITE:  n = 5'd25;
      RUN_READ:   n = 5'd3;
      RUN_ACKW:   n = 5'd2;
      RUN_POLL:   n = 5'd1;
      RUN_ACKOK:  n = 5'd1;
      RUN_RDBIT:  n = 5'd3;
      RUN_RDLAST: n = 5'd5;
      default:    n = 5'd1;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

>>> rtl/i2cmbe_seq.sv
`default_nettype none

module i2cmbe_seq
  import i2cmbe_pkg::*;
(
  input  wire   clk,
  input  wire   rst,
  input  cfg_t  cfg,
  input  wire   in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  wire   step_ready,
  output logic  step_valid,
  output step_t step
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t     state;
  run_t       run;
  logic [4:0] idx;
  logic [1:0] phase;
  logic [7:0] tx_shift;
  logic       run_rxv;
  ack_t       run_ack;

  pend_t      pending_operation;
  logic [3:0] bit_counter;
  logic [7:0] receive_shift;
  logic [7:0] poll_counter;
  logic       ack_choice;

  logic       line_scl;
  logic       line_sda;
  logic       line_drive;

  pin_t       pin;
  logic       emit;
  logic       is_last;
  logic [8:0] poll_next;
  logic [7:0] shift_next;
  logic [3:0] bits_next;

  assign in_ready   = (state == ST_IDLE);
  assign step_valid = (state == ST_RUN);
  assign emit       = (state == ST_RUN) && step_ready;
  assign is_last    = (idx == run_len(run) - 5'd1);

  assign poll_next  = {1'b0, poll_counter} + 9'd1;
  assign shift_next = {receive_shift[6:0], in_item.sda_sample};
  assign bits_next  = bit_counter + 4'd1;

  always_comb begin
    pin = mk_pin(line_scl, line_sda, line_drive, 8'd0, 1'b0);
    case (run)
      RUN_IDLE: pin = mk_pin(1'b1, 1'b1, 1'b1, 8'd0, 1'b0);
      RUN_START: begin
        case (idx[1:0])
          2'd0:    pin = mk_pin(line_scl, 1'b1, 1'b1, 8'd0, 1'b0);
          2'd1:    pin = mk_pin(1'b1, 1'b1, 1'b1, cfg.setup_wait, 1'b0);
          2'd2:    pin = mk_pin(1'b1, 1'b0, 1'b1, cfg.setup_wait, 1'b0);
          default: pin = mk_pin(1'b0, 1'b0, 1'b1, 8'd0, 1'b0);
        endcase
      end
      RUN_STOP: begin
        case (idx[1:0])
          2'd0:    pin = mk_pin(1'b0, line_sda, 1'b1, 8'd0, 1'b0);
          2'd1:    pin = mk_pin(1'b0, 1'b0, 1'b1, cfg.setup_wait, 1'b0);
          2'd2:    pin = mk_pin(1'b1, 1'b0, 1'b1, 8'd0, 1'b0);
          default: pin = mk_pin(1'b1, 1'b1, 1'b1, cfg.setup_wait, 1'b0);
        endcase
      end
      RUN_WRITE: begin
        if (idx == 5'd0) begin
          pin = mk_pin(1'b0, line_sda, 1'b1, 8'd0, 1'b0);
        end else begin
          pin = mk_pin(phase == 2'd1, tx_shift[7], 1'b1, cfg.half_bit_wait, 1'b0);
        end
      end
      RUN_READ: begin
        case (idx[1:0])
          2'd0:    pin = mk_pin(line_scl, 1'b1, 1'b0, 8'd0, 1'b0);
          2'd1:    pin = mk_pin(1'b0, 1'b1, 1'b0, cfg.half_bit_wait, 1'b0);
          default: pin = mk_pin(1'b1, 1'b1, 1'b0, 8'd0, 1'b1);
        endcase
      end
      RUN_ACKW: begin
        if (idx == 5'd0) begin
          pin = mk_pin(line_scl, 1'b1, 1'b0, cfg.sample_wait, 1'b0);
        end else begin
          pin = mk_pin(1'b1, 1'b1, 1'b0, cfg.sample_wait, 1'b1);
        end
      end
      RUN_POLL:  pin = mk_pin(line_scl, line_sda, line_drive, 8'd0, 1'b1);
      RUN_ACKOK: pin = mk_pin(1'b0, line_sda, line_drive, 8'd0, 1'b0);
      RUN_RDBIT: begin
        case (idx[1:0])
          2'd0:    pin = mk_pin(line_scl, line_sda, line_drive, cfg.sample_wait, 1'b0);
          2'd1:    pin = mk_pin(1'b0, 1'b1, 1'b0, cfg.half_bit_wait, 1'b0);
          default: pin = mk_pin(1'b1, 1'b1, 1'b0, 8'd0, 1'b1);
        endcase
      end
      RUN_RDLAST: begin
        case (idx[2:0])
          3'd0:    pin = mk_pin(line_scl, line_sda, line_drive, cfg.sample_wait, 1'b0);
          3'd1:    pin = mk_pin(1'b0, line_sda, line_drive, 8'd0, 1'b0);
          3'd2:    pin = mk_pin(1'b0, !ack_choice, 1'b1, cfg.half_bit_wait, 1'b0);
          3'd3:    pin = mk_pin(1'b1, line_sda, 1'b1, cfg.half_bit_wait, 1'b0);
          default: pin = mk_pin(1'b0, line_sda, 1'b1, 8'd0, 1'b0);
        endcase
      end
      default: pin = mk_pin(line_scl, line_sda, line_drive, 8'd0, 1'b0);
    endcase
  end

  always_comb begin
    step.pin        = pin;
    step.rx_valid   = run_rxv;
    step.rx_byte    = run_rxv ? receive_shift : 8'd0;
    step.ack_status = run_ack;
    step.last       = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      run               <= RUN_IDLE;
      idx               <= 5'd0;
      phase             <= 2'd0;
      tx_shift          <= 8'd0;
      run_rxv           <= 1'b0;
      run_ack           <= ACK_NONE;
      pending_operation <= PEND_NONE;
      bit_counter       <= 4'd0;
      receive_shift     <= 8'd0;
      poll_counter      <= 8'd0;
      ack_choice        <= 1'b0;
      line_scl          <= 1'b1;
      line_sda          <= 1'b1;
      line_drive        <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            idx     <= 5'd0;
            phase   <= 2'd0;
            run_rxv <= 1'b0;
            run_ack <= ACK_NONE;
            if (in_item.req_type == REQ_SAMPLE) begin
              // a sample with nothing pending is dropped without a run
              if (pending_operation == PEND_ACK) begin
                state <= ST_RUN;
                if (in_item.sda_sample) begin
                  if (poll_next > {1'b0, cfg.ack_timeout}) begin
                    pending_operation <= PEND_NONE;
                    poll_counter      <= 8'd0;
                    run               <= RUN_STOP;
                    run_ack           <= ACK_FAIL;
                  end else begin
                    poll_counter <= poll_next[7:0];
                    run          <= RUN_POLL;
                  end
                end else begin
                  pending_operation <= PEND_NONE;
                  run               <= RUN_ACKOK;
                  run_ack           <= ACK_OK;
                end
              end else if (pending_operation == PEND_READ) begin
                state         <= ST_RUN;
                receive_shift <= shift_next;
                bit_counter   <= bits_next;
                if (bits_next < READ_BITS) begin
                  run <= RUN_RDBIT;
                end else begin
                  pending_operation <= PEND_NONE;
                  run               <= RUN_RDLAST;
                  run_rxv           <= 1'b1;
                end
              end
            end else if (in_item.req_type inside {REQ_IDLE, REQ_START, REQ_STOP,
                                                  REQ_WRITE, REQ_READ, REQ_ACKW}) begin
              state             <= ST_RUN;
              pending_operation <= PEND_NONE;
              case (in_item.req_type)
                REQ_IDLE:  run <= RUN_IDLE;
                REQ_START: run <= RUN_START;
                REQ_STOP:  run <= RUN_STOP;
                REQ_WRITE: begin
                  run      <= RUN_WRITE;
                  tx_shift <= in_item.tx_byte;
                end
                REQ_READ: begin
                  run               <= RUN_READ;
                  ack_choice        <= in_item.send_ack;
                  bit_counter       <= 4'd0;
                  receive_shift     <= 8'd0;
                  pending_operation <= PEND_READ;
                end
                default: begin
                  run               <= RUN_ACKW;
                  poll_counter      <= 8'd0;
                  pending_operation <= PEND_ACK;
                end
              endcase
            end
          end
        end
        ST_RUN: begin
          if (emit) begin
            line_scl   <= pin.scl_level;
            line_sda   <= pin.sda_level;
            line_drive <= pin.sda_drive;
            idx        <= idx + 5'd1;
            // advance the byte one bit after the low, high, low phases
            if (run == RUN_WRITE && idx != 5'd0) begin
              if (phase == 2'd2) begin
                phase    <= 2'd0;
                tx_shift <= {tx_shift[6:0], 1'b0};
              end else begin
                phase <= phase + 2'd1;
              end
            end
            if (is_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/i2c_master_bit_engine_core.sv
`default_nettype none

// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  command or SDA sample beat
// m_*      out  m_tvalid/m_tready  one pin step per beat, m_tlast ends a run
// cfg_*    in   cfg_valid/cfg_ready  register write, always ready
//
// A command is accepted while the step sequencer is idle; the sequencer then
// emits one pin step a cycle into the output register unless m_tready stalls it.
// A sample with nothing pending, or an unused code, is accepted and dropped without a run.
// Reset releases the bus lines and restores the register defaults.
// A stalled m_tready holds the step sequencer; no new beat is taken mid-run.

module i2c_master_bit_engine_core
  import i2cmbe_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [15:0] s_tdata,   // tx_byte[7:0], send_ack[8], sda_sample[9], zero pad
  input  wire  [2:0]  s_tuser,   // req_type
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [23:0] m_tdata,   // scl_level[0], sda_level[1], sda_drive[2],
                                 // wait_us[10:3], sample_request[11], rx_valid[12],
                                 // rx_byte[20:13], ack_status[22:21], zero pad
  output logic        m_tlast,   // last
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [7:0]  cfg_data
);

  cfg_t  cfg;
  item_t item;
  step_t step;
  logic  step_valid;
  logic  step_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setup_wait    <= SETUP_RST;
      cfg.half_bit_wait <= HALF_RST;
      cfg.sample_wait   <= SAMPLE_RST;
      cfg.ack_timeout   <= TMO_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SETUP:  cfg.setup_wait    <= cfg_data;
        CFG_HALF:   cfg.half_bit_wait <= cfg_data;
        CFG_SAMPLE: cfg.sample_wait   <= cfg_data;
        default:    cfg.ack_timeout   <= cfg_data;
      endcase
    end
  end

  always_comb begin
    item.req_type   = s_tuser;
    item.tx_byte    = s_tdata[7:0];
    item.send_ack   = s_tdata[8];
    item.sda_sample = s_tdata[9];
  end

  assign step_ready = !m_tvalid || m_tready;

  i2cmbe_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (item),
    .step_ready (step_ready),
    .step_valid (step_valid),
    .step       (step)
  );

  // output register: load a fresh step whenever the slot is free or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step_ready) begin
      m_tvalid <= step_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_ready && step_valid) begin
      m_tdata <= {1'b0, step.ack_status, step.rx_byte, step.rx_valid,
                  step.pin.sample_request, step.pin.wait_us, step.pin.sda_drive,
                  step.pin.sda_level, step.pin.scl_level};
      m_tlast <= step.last;
    end
  end

endmodule

`default_nettype wire
